// ===== rtl/core/key_matrix_debounce_unit_macros.svh =====
// Assertion macros for the key matrix debounce unit.
// They expect i_clk and i_rst_n in the scope where they are used.
`ifndef KEY_MATRIX_DEBOUNCE_UNIT_MACROS_SVH
`define KEY_MATRIX_DEBOUNCE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked out of reset only.
`define KMD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define KMD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define KMD_ASSERT(lbl, prop, msg)
`define KMD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== rtl/core/kmd_pkg.sv =====
package kmd_pkg;

    localparam int ROWS = 5;
    localparam int COLS = 16;

    localparam int COL_W   = 4;
    localparam int ROW_W   = 5;
    localparam int SCAN_W  = 8;
    localparam int COUNT_W = 7;
    localparam int POP_W   = $clog2(ROWS + 1);

    localparam logic [SCAN_W-1:0] SETTLE_RESET = SCAN_W'(5);

    typedef logic [ROWS-1:0]    t_row;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [SCAN_W-1:0]  t_scan;

    // Per-item status from the matrix store to the control logic.
    typedef struct packed {
        logic   in_range;
        logic   changed;
        t_row   stable_keys;
        t_count raw_total_next;
    } t_mat_stat;

    function automatic logic [POP_W-1:0] pop_rows(input t_row v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int r = 0; r < ROWS; r++) begin
            n = n + POP_W'(v[r]);
        end
        return n;
    endfunction

endpackage

// ===== rtl/core/kmd_item_if.sv =====
interface kmd_item_if
    import kmd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   row_bits;
    logic               end_of_scan;

    modport source (output valid, column, row_bits, end_of_scan, input ready);
    modport sink   (input valid, column, row_bits, end_of_scan, output ready);
endinterface

// ===== rtl/core/kmd_result_if.sv =====
interface kmd_result_if
    import kmd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [ROW_W-1:0]   column_keys;
    logic               settled;
    logic               committed;
    logic [COUNT_W-1:0] key_count;

    modport source (output valid, column_keys, settled, committed, key_count, input ready);
    modport sink   (input valid, column_keys, settled, committed, key_count, output ready);
endinterface

// ===== rtl/core/kmd_cfg_if.sv =====
interface kmd_cfg_if
    import kmd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [SCAN_W-1:0] settle_scans;

    modport source (output valid, settle_scans, input ready);
    modport sink   (input valid, settle_scans, output ready);
endinterface

// ===== rtl/core/kmd_matrix.sv =====
`include "key_matrix_debounce_unit_macros.svh"

module kmd_matrix
    import kmd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [COL_W-1:0] i_column,
    input  t_row             i_rows,
    input  logic             i_commit,
    output t_mat_stat        o_stat
);

    t_row   r_raw    [COLS];
    t_row   r_stable [COLS];
    t_count r_raw_total;

    logic   w_in_range;
    logic   w_changed;
    t_row   w_raw_col;
    t_count w_total_next;

    always_comb begin
        w_in_range = 32'(i_column) < COLS;
        w_raw_col  = w_in_range ? r_raw[i_column] : '0;
        w_changed  = w_in_range && (w_raw_col != i_rows);
        // running count of pressed raw keys, adjusted by this column's change
        w_total_next = w_changed
            ? r_raw_total - COUNT_W'(pop_rows(w_raw_col)) + COUNT_W'(pop_rows(i_rows))
            : r_raw_total;
    end

    assign o_stat.in_range       = w_in_range;
    assign o_stat.changed        = w_changed;
    assign o_stat.stable_keys    = w_in_range ? r_stable[i_column] : '0;
    assign o_stat.raw_total_next = w_total_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < COLS; c++) begin
                r_raw[c]    <= '0;
                r_stable[c] <= '0;
            end
            r_raw_total <= '0;
        end else if (i_accept) begin
            if (w_changed) begin
                r_raw[i_column] <= i_rows;
                r_raw_total     <= w_total_next;
            end
            if (i_commit) begin
                // copy includes the column written in this same transaction
                for (int c = 0; c < COLS; c++) begin
                    r_stable[c] <= (w_in_range && (COL_W'(c) == i_column))
                                   ? i_rows : r_raw[c];
                end
            end
        end
    end

    `KMD_ASSERT(a_total_idle, !i_accept |=> $stable(r_raw_total), "raw total moved without a transaction")
    `KMD_ASSERT(a_total_range, r_raw_total <= COUNT_W'(ROWS * COLS), "raw total out of range")
    `KMD_ASSERT(a_commit_col, i_accept && i_commit && w_in_range |=> r_stable[$past(i_column)] == r_raw[$past(i_column)], "committed column differs from raw")

endmodule

// ===== rtl/core/key_matrix_debounce_unit.sv =====
// Channel   Dir  Transaction payload
// i_item    in   column, row_bits, end_of_scan
// o_result  out  column_keys, settled, committed, key_count
// i_cfg     in   settle_scans (always ready)
//
// One item per cycle unless o_result stalls; each accepted item yields its
// result in the next cycle from the output register. The raw compare, counter
// reload/countdown and commit all resolve in the accept cycle. i_item is ready
// whenever the output register is empty or being drained, so a stall on o_result stalls input.
// Synchronous reset clears both matrices and loads the counter with 5.
`include "key_matrix_debounce_unit_macros.svh"

module key_matrix_debounce_unit
    import kmd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    kmd_item_if.sink      i_item,
    kmd_result_if.source  o_result,
    kmd_cfg_if.sink       i_cfg
);

    t_scan     r_settle_scans;
    t_scan     r_settle_cnt;
    t_count    r_pressed_total;

    logic      r_out_valid;
    t_row      r_out_keys;
    logic      r_out_settled;
    logic      r_out_committed;
    t_count    r_out_count;

    t_mat_stat w_stat;
    logic      w_accept;
    t_scan     w_reload;
    t_scan     n_settle_cnt;
    t_scan     w_cnt_loaded;
    logic      w_dec;
    logic      w_commit;
    t_row      w_rows;
    t_row      w_keys;
    t_count    n_pressed_total;

    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign w_accept     = i_item.valid && i_item.ready;
    assign w_rows       = t_row'(i_item.row_bits);

    kmd_matrix u_matrix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_column (i_item.column),
        .i_rows   (w_rows),
        .i_commit (w_commit),
        .o_stat   (w_stat)
    );

    always_comb begin
        // zero setting behaves as one pass
        w_reload     = (r_settle_scans == '0) ? SCAN_W'(1) : r_settle_scans;
        w_cnt_loaded = w_stat.changed ? w_reload : r_settle_cnt;
        w_dec        = i_item.end_of_scan && (w_cnt_loaded != '0);
        w_commit     = w_dec && (w_cnt_loaded == SCAN_W'(1));
        n_settle_cnt = w_dec ? w_cnt_loaded - SCAN_W'(1) : w_cnt_loaded;
        n_pressed_total = w_commit ? w_stat.raw_total_next : r_pressed_total;
        if (!w_stat.in_range) begin
            w_keys = '0;
        end else if (w_commit) begin
            w_keys = w_rows;
        end else begin
            w_keys = w_stat.stable_keys;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_scans  <= SETTLE_RESET;
            r_settle_cnt    <= SETTLE_RESET;
            r_pressed_total <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_settle_scans <= i_cfg.settle_scans;
            end
            if (w_accept) begin
                r_settle_cnt    <= n_settle_cnt;
                r_pressed_total <= n_pressed_total;
                r_out_valid     <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_keys      <= w_keys;
            r_out_settled   <= (n_settle_cnt == '0);
            r_out_committed <= w_commit;
            r_out_count     <= n_pressed_total;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.column_keys = r_out_keys;
    assign o_result.settled     = r_out_settled;
    assign o_result.committed   = r_out_committed;
    assign o_result.key_count   = r_out_count;

    `KMD_ASSERT(a_commit_zero, w_accept && w_commit |=> r_settle_cnt == '0, "commit left counter nonzero")
    `KMD_ASSERT(a_cnt_idle, !w_accept |=> $stable(r_settle_cnt) && $stable(r_pressed_total), "counter moved without a transaction")
    `KMD_ASSERT(a_commit_settled, r_out_valid && r_out_committed |-> r_out_settled, "commit reported while unsettled")
    `KMD_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !r_out_valid, "result valid right after reset")

endmodule
